FILE: rtl/trw_pkg.sv
// Shared constants for the text reflow, indent and wrap block.
`default_nettype none

package trw_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned COLUMN_W    = 8;
    localparam int unsigned INDENT_W    = 5;
    localparam int unsigned HEADER_W    = 16;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 1;

    localparam int unsigned MAX_INDENT_DEFAULT = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_COLUMN   = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BYTES = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [COLUMN_W-1:0] MAX_COLUMN_RESET   = 8'd78;
    localparam logic [HEADER_W-1:0] HEADER_BYTES_RESET = 16'd1536;

    // Character codes.
    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_TERM  = 8'h1A;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    // Column step of one emitted tab.
    localparam logic [COLUMN_W:0] TAB_WIDTH = 9'd8;

endpackage

`default_nettype wire

FILE: rtl/text_reflow_indent_wrap_top.sv
// Top level of the text reflow block: header skip, indentation, wrapping and termination.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+---------------------------------------
//   in      | input     | in_valid / in_stall | in_byte, end_of_input
//   out     | output    | out_valid/out_stall | out_byte, last_of_run, finished
//   cfg     | input     | cfg_wr_en           | cfg_index, cfg_data
//
// An input beat is taken only while the sequencer is idle; it then emits its result bytes
// one per cycle through the output register while the output does not stall, and keeps
// the input stalled until the last is placed; a beat with no result does not stall it.
// The one saturating column adder is shared by the tab and character steps. A stall on
// the output holds the sequencer in place. Reset clears the indent, column and finished
// state, restores the register defaults and reloads the header count.
`default_nettype none

module text_reflow_indent_wrap_top
    import trw_pkg::*;
#(
    parameter int unsigned MAX_INDENT = MAX_INDENT_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [BYTE_W-1:0]      in_byte,
    input  wire logic                   end_of_input,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [BYTE_W-1:0]           out_byte,
    output logic                        last_of_run,
    output logic                        finished,

    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [INDENT_W-1:0] INDENT_LIMIT = INDENT_W'(MAX_INDENT);

    // Sequencer steps: each busy state places exactly one byte in the output register.
    typedef enum logic [2:0] {
        S_IDLE,
        S_TAB,
        S_CHAR,
        S_CR,
        S_LF,
        S_TERM
    } state_t;

    state_t                 state_reg,      state_next;
    logic [INDENT_W-1:0]    indent_reg,     indent_next;
    logic [COLUMN_W-1:0]    column_reg,     column_next;
    logic [HEADER_W-1:0]    header_left_reg, header_left_next;
    logic                   done_reg,       done_next;
    logic [COLUMN_W-1:0]    max_column_reg, max_column_next;
    logic [INDENT_W-1:0]    tab_cnt_reg,    tab_cnt_next;
    logic [BYTE_W-1:0]      char_reg,       char_next;
    logic                   term_reg,       term_next;

    logic                   out_valid_reg,  out_valid_next;
    logic [BYTE_W-1:0]      out_byte_reg,   out_byte_next;
    logic                   out_last_reg,   out_last_next;
    logic                   out_fin_reg,    out_fin_next;

    logic                   in_accept;
    logic                   slot_free;
    logic                   is_term;
    logic [COLUMN_W:0]      col_step;
    logic [COLUMN_W:0]      col_sum;
    logic [COLUMN_W-1:0]    col_sat;
    logic                   wrap;

    assign in_stall    = (state_reg != S_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign slot_free   = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;
    assign finished    = out_fin_reg;

    // The one shared unit: a saturating adder on the column count.
    assign col_step = (state_reg == S_TAB) ? TAB_WIDTH : (COLUMN_W+1)'(1);
    assign col_sum  = {1'b0, column_reg} + col_step;
    assign col_sat  = col_sum[COLUMN_W] ? {COLUMN_W{1'b1}} : col_sum[COLUMN_W-1:0];
    assign wrap     = (char_reg == CH_SPACE) && (col_sat > max_column_reg);

    assign is_term = end_of_input
                  || ((header_left_reg == '0) && ((in_byte == CH_NUL) || (in_byte == CH_TERM)));

    always_comb
    begin
        state_next       = state_reg;
        indent_next      = indent_reg;
        column_next      = column_reg;
        header_left_next = header_left_reg;
        done_next        = done_reg;
        max_column_next  = max_column_reg;
        tab_cnt_next     = tab_cnt_reg;
        char_next        = char_reg;
        term_next        = term_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_byte_next    = out_byte_reg;
        out_last_next    = out_last_reg;
        out_fin_next     = out_fin_reg;

        // Configuration writes must arrive only while the block is idle; the block does not enforce it.
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MAX_COLUMN:   max_column_next  = cfg_data[COLUMN_W-1:0];
                CFG_HEADER_BYTES: header_left_next = cfg_data[HEADER_W-1:0];
                default:          ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && !done_reg)
                begin
                    priority if (is_term)
                    begin
                        term_next  = 1'b1;
                        done_next  = 1'b1;
                        state_next = S_CR;
                    end
                    else if (header_left_reg != '0)
                    begin
                        header_left_next = header_left_reg - HEADER_W'(1);
                    end
                    else if (in_byte == CH_TAB)
                    begin
                        if (indent_reg < INDENT_LIMIT)
                        begin
                            indent_next = indent_reg + INDENT_W'(1);
                        end
                    end
                    else if (in_byte == CH_BS)
                    begin
                        if (indent_reg != '0)
                        begin
                            indent_next = indent_reg - INDENT_W'(1);
                        end
                    end
                    else if (in_byte == CH_CR)
                    begin
                        term_next   = 1'b0;
                        column_next = '0;
                        state_next  = S_CR;
                    end
                    else
                    begin
                        char_next    = in_byte;
                        tab_cnt_next = indent_reg;
                        if ((column_reg == '0) && (indent_reg != '0))
                        begin
                            state_next = S_TAB;
                        end
                        else
                        begin
                            state_next = S_CHAR;
                        end
                    end
                end
            end

            S_TAB:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CH_TAB;
                    out_last_next  = 1'b0;
                    out_fin_next   = 1'b0;
                    column_next    = col_sat;
                    tab_cnt_next   = tab_cnt_reg - INDENT_W'(1);
                    if (tab_cnt_reg == INDENT_W'(1))
                    begin
                        state_next = S_CHAR;
                    end
                end
            end

            S_CHAR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = char_reg;
                    out_last_next  = !wrap;
                    out_fin_next   = 1'b0;
                    if (wrap)
                    begin
                        column_next = '0;
                        term_next   = 1'b0;
                        state_next  = S_CR;
                    end
                    else
                    begin
                        column_next = col_sat;
                        state_next  = S_IDLE;
                    end
                end
            end

            S_CR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CH_CR;
                    out_last_next  = 1'b0;
                    out_fin_next   = term_reg;
                    state_next     = S_LF;
                end
            end

            S_LF:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CH_LF;
                    out_last_next  = !term_reg;
                    out_fin_next   = term_reg;
                    state_next     = term_reg ? S_TERM : S_IDLE;
                end
            end

            S_TERM:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = CH_TERM;
                    out_last_next  = 1'b1;
                    out_fin_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            indent_reg      <= '0;
            column_reg      <= '0;
            header_left_reg <= HEADER_BYTES_RESET;
            done_reg        <= 1'b0;
            max_column_reg  <= MAX_COLUMN_RESET;
            tab_cnt_reg     <= '0;
            char_reg        <= '0;
            term_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_byte_reg    <= '0;
            out_last_reg    <= 1'b0;
            out_fin_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            indent_reg      <= indent_next;
            column_reg      <= column_next;
            header_left_reg <= header_left_next;
            done_reg        <= done_next;
            max_column_reg  <= max_column_next;
            tab_cnt_reg     <= tab_cnt_next;
            char_reg        <= char_next;
            term_reg        <= term_next;
            out_valid_reg   <= out_valid_next;
            out_byte_reg    <= out_byte_next;
            out_last_reg    <= out_last_next;
            out_fin_reg     <= out_fin_next;
        end
    end

endmodule

`default_nettype wire
